// File: src/ffha_pkg.sv
// Package for the first-fit heap allocator: sizes, chunk table entry type,
// command and status codes, and the controller state type.
// No dependencies.
package ffha_pkg;

    // Heap geometry
    localparam int HEAP_WORDS   = 512;
    localparam int HEADER_BYTES = 24;
    localparam int HDR_WORDS    = (HEADER_BYTES + 7) / 8;

    // Byte offsets on the ports, and the word part of such an offset
    localparam int OFS_W  = 12;
    localparam int WOFS_W = OFS_W - 3;

    // Table index, stored chunk size, and working width of walk arithmetic
    localparam int ADDR_W   = $clog2(HEAP_WORDS);
    localparam int SIZE_W   = $clog2(HEAP_WORDS + 1);
    localparam int NEED_MAX = (1 << WOFS_W) + 2 * HDR_WORDS + 1;
    localparam int CNT_MAX  = (HEAP_WORDS > NEED_MAX) ? HEAP_WORDS : NEED_MAX;
    localparam int CNT_W    = $clog2(CNT_MAX * 2);
    localparam int ENTRY_W  = SIZE_W + 1;

    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic              free;
    } entry_t;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic {
        STATUS_OK   = 1'b0,
        STATUS_FAIL = 1'b1
    } status_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_WALK,
        ST_SPLIT,
        ST_MERGE,
        ST_DONE
    } state_t;

endpackage

// File: src/first_fit_heap_allocator_unit.sv
// First-fit heap allocator over a chunk table held in one RAM (ffha_ram).
// Depends on ffha_pkg and ffha_ram.
//
// The block keeps a heap of HEAP_WORDS eight-byte words as a chain of chunks
// whose size and free mark sit in a chunk table RAM, one entry per word. An
// allocate walks the chain from word 0 reading one chunk per cycle through the
// RAM read port, marks the first free chunk that fits and, in ST_SPLIT, writes
// the split-off remainder; a free walks the chain the same way to check its
// address, then reads the following chunk, if there is one, for a merge. A null
// or malformed free answers without a walk. Items are handled one at a time;
// the next item is taken while a result still waits in the output register.
// After reset the block writes the initial free chunk in ST_INIT and takes no
// item while doing so. Every result is status plus payload offset (0 on
// failure and for every free).
module first_fit_heap_allocator_unit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_cmd,
    input  logic [11:0]               s_req_size,
    input  logic [11:0]               s_payload_addr,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_status,
    output logic [11:0]               m_result_addr
);

    ffha_pkg::state_t state_reg, state_next;

    logic                         cmd_reg, cmd_next;
    logic [ffha_pkg::CNT_W-1:0]   need_reg, need_next;
    logic [ffha_pkg::CNT_W-1:0]   c_reg, c_next;
    logic [ffha_pkg::CNT_W-1:0]   pos_reg, pos_next;
    logic [ffha_pkg::CNT_W-1:0]   sz_reg, sz_next;
    logic                         res_status_reg, res_status_next;
    logic [ffha_pkg::OFS_W-1:0]   res_addr_reg, res_addr_next;
    logic                         m_valid_reg, m_valid_next;
    logic                         m_status_reg, m_status_next;
    logic [ffha_pkg::OFS_W-1:0]   m_addr_reg, m_addr_next;

    logic                          ram_we;
    logic [ffha_pkg::ADDR_W-1:0]   ram_waddr;
    ffha_pkg::entry_t              ram_wentry;
    logic [ffha_pkg::ADDR_W-1:0]   ram_raddr;
    logic [ffha_pkg::ENTRY_W-1:0]  ram_rdata;

    ffha_pkg::entry_t              rd_ent;
    logic [ffha_pkg::CNT_W-1:0]    sz;
    logic [ffha_pkg::CNT_W-1:0]    nxt;
    logic [ffha_pkg::CNT_W-1:0]    in_need;
    logic [ffha_pkg::CNT_W-1:0]    in_word;
    logic [ffha_pkg::CNT_W-1:0]    head_ofs;
    logic                          accept;
    logic                          free_ok;
    logic                          at_end;
    logic                          fit;
    logic                          split;
    logic                          hit;
    logic                          past;
    logic                          out_free;

    ffha_ram #(
        .WIDTH(ffha_pkg::ENTRY_W),
        .DEPTH(ffha_pkg::HEAP_WORDS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decode the incoming item and the chunk just read
    always_comb begin
        accept   = s_valid && s_ready;
        // round the request up to whole words, then add the header
        in_need  = ffha_pkg::CNT_W'(s_req_size[ffha_pkg::OFS_W-1:3])
                 + ffha_pkg::CNT_W'(|s_req_size[2:0])
                 + ffha_pkg::CNT_W'(ffha_pkg::HDR_WORDS);
        in_word  = ffha_pkg::CNT_W'(s_payload_addr[ffha_pkg::OFS_W-1:3]);
        free_ok  = (s_payload_addr != '0) && (s_payload_addr[2:0] == 3'd0)
                 && (in_word >= ffha_pkg::CNT_W'(ffha_pkg::HDR_WORDS))
                 && (in_word - ffha_pkg::CNT_W'(ffha_pkg::HDR_WORDS)
                     < ffha_pkg::CNT_W'(ffha_pkg::HEAP_WORDS));
        rd_ent   = ffha_pkg::entry_t'(ram_rdata);
        sz       = ffha_pkg::CNT_W'(rd_ent.size);
        nxt      = pos_reg + sz;
        at_end   = pos_reg >= ffha_pkg::CNT_W'(ffha_pkg::HEAP_WORDS);
        fit      = rd_ent.free && (sz >= need_reg);
        split    = sz >= need_reg + ffha_pkg::CNT_W'(ffha_pkg::HDR_WORDS + 1);
        hit      = pos_reg == c_reg;
        past     = pos_reg > c_reg;
        head_ofs = pos_reg + ffha_pkg::CNT_W'(ffha_pkg::HDR_WORDS);
        out_free = !m_valid_reg || m_ready;
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ffha_pkg::ST_INIT: begin
                state_next = ffha_pkg::ST_IDLE;
            end
            ffha_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_cmd == ffha_pkg::CMD_ALLOC || free_ok) begin
                        state_next = ffha_pkg::ST_WALK;
                    end else begin
                        state_next = ffha_pkg::ST_DONE;
                    end
                end
            end
            ffha_pkg::ST_WALK: begin
                if (at_end || sz == '0) begin
                    state_next = ffha_pkg::ST_DONE;
                end else if (cmd_reg == ffha_pkg::CMD_ALLOC) begin
                    if (fit) begin
                        state_next = split ? ffha_pkg::ST_SPLIT : ffha_pkg::ST_DONE;
                    end
                end else if (hit) begin
                    state_next = (nxt < ffha_pkg::CNT_W'(ffha_pkg::HEAP_WORDS))
                               ? ffha_pkg::ST_MERGE : ffha_pkg::ST_DONE;
                end else if (past) begin
                    state_next = ffha_pkg::ST_DONE;
                end
            end
            ffha_pkg::ST_SPLIT: begin
                state_next = ffha_pkg::ST_DONE;
            end
            ffha_pkg::ST_MERGE: begin
                state_next = ffha_pkg::ST_DONE;
            end
            ffha_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = ffha_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ffha_pkg::ST_INIT;
            end
        endcase
    end

    // Table accesses, walk registers and result
    always_comb begin
        cmd_next        = cmd_reg;
        need_next       = need_reg;
        c_next          = c_reg;
        pos_next        = pos_reg;
        sz_next         = sz_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_status_next   = m_status_reg;
        m_addr_next     = m_addr_reg;
        ram_we          = 1'b0;
        ram_waddr       = pos_reg[ffha_pkg::ADDR_W-1:0];
        ram_wentry      = '0;
        ram_raddr       = '0;
        s_ready         = 1'b0;

        case (state_reg)
            // Write the whole heap as one free chunk
            ffha_pkg::ST_INIT: begin
                ram_we          = 1'b1;
                ram_waddr       = '0;
                ram_wentry.size = ffha_pkg::SIZE_W'(ffha_pkg::HEAP_WORDS);
                ram_wentry.free = 1'b1;
            end
            // Take an item and start the walk at word 0
            ffha_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    cmd_next        = s_cmd;
                    need_next       = in_need;
                    c_next          = in_word - ffha_pkg::CNT_W'(ffha_pkg::HDR_WORDS);
                    pos_next        = '0;
                    res_status_next = ffha_pkg::STATUS_OK;
                    res_addr_next   = '0;
                end
            end
            // One chunk per cycle: check it, or issue the read of the next one
            ffha_pkg::ST_WALK: begin
                sz_next = sz;
                if (at_end || sz == '0) begin
                    if (cmd_reg == ffha_pkg::CMD_ALLOC) begin
                        res_status_next = ffha_pkg::STATUS_FAIL;
                    end
                end else if (cmd_reg == ffha_pkg::CMD_ALLOC) begin
                    if (fit) begin
                        ram_we          = 1'b1;
                        ram_wentry.size = split ? need_reg[ffha_pkg::SIZE_W-1:0]
                                                : rd_ent.size;
                        ram_wentry.free = 1'b0;
                        res_addr_next   = {head_ofs[ffha_pkg::WOFS_W-1:0], 3'b000};
                    end else begin
                        pos_next  = nxt;
                        ram_raddr = nxt[ffha_pkg::ADDR_W-1:0];
                    end
                end else if (hit) begin
                    if (nxt < ffha_pkg::CNT_W'(ffha_pkg::HEAP_WORDS)) begin
                        ram_raddr = nxt[ffha_pkg::ADDR_W-1:0];
                    end else begin
                        ram_we          = 1'b1;
                        ram_wentry.size = rd_ent.size;
                        ram_wentry.free = 1'b1;
                    end
                end else if (!past) begin
                    pos_next  = nxt;
                    ram_raddr = nxt[ffha_pkg::ADDR_W-1:0];
                end
            end
            // Write the split-off remainder as a free chunk
            ffha_pkg::ST_SPLIT: begin
                ram_we          = 1'b1;
                ram_waddr       = ffha_pkg::ADDR_W'(pos_reg + need_reg);
                ram_wentry.size = ffha_pkg::SIZE_W'(sz_reg - need_reg);
                ram_wentry.free = 1'b1;
            end
            // Mark the freed chunk, absorbing the following chunk if free
            ffha_pkg::ST_MERGE: begin
                ram_we          = 1'b1;
                ram_waddr       = c_reg[ffha_pkg::ADDR_W-1:0];
                ram_wentry.size = rd_ent.free
                                ? ffha_pkg::SIZE_W'(sz_reg + sz)
                                : sz_reg[ffha_pkg::SIZE_W-1:0];
                ram_wentry.free = 1'b1;
            end
            // Hand the result to the output register
            ffha_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_addr_next   = res_addr_reg;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ffha_pkg::ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        need_reg       <= need_next;
        c_reg          <= c_next;
        pos_reg        <= pos_next;
        sz_reg         <= sz_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        m_status_reg   <= m_status_next;
        m_addr_reg     <= m_addr_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_result_addr = m_addr_reg;

    // No table write while waiting for an item
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ffha_pkg::ST_IDLE |-> !ram_we)
        else $error("table written while idle");

    // A failed allocation reports a null offset
    a_fail_null: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ffha_pkg::STATUS_FAIL) |-> m_result_addr == '0)
        else $error("failed allocation with nonzero offset");

    // The walk never runs past the end of the heap
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ffha_pkg::ST_WALK
        |-> pos_reg <= ffha_pkg::CNT_W'(ffha_pkg::HEAP_WORDS))
        else $error("walk position beyond heap");

    // An accepted transfer always leaves the idle state
    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg != ffha_pkg::ST_IDLE)
        else $error("item accepted but controller stayed idle");

    // A free never reports failure
    a_free_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ffha_pkg::ST_DONE && cmd_reg == ffha_pkg::CMD_FREE)
        |-> res_status_reg == ffha_pkg::STATUS_OK && res_addr_reg == '0)
        else $error("free produced a nonzero result");

endmodule

// File: src/ffha_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and register the read data
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
